>>> hdl/mfpe_pkg.sv
// ----------------------------------------------------------------------------
// mfpe_pkg
// shared types and constants for the manchester frame pulse encoder
// ----------------------------------------------------------------------------
`default_nettype none

package mfpe_pkg;

    // field widths
    localparam int unsigned HALF_W  = 13;
    localparam int unsigned SYNC_W  = 16;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CNT_W   = 4;

    // register reset values
    localparam logic [HALF_W-1:0] HALF_BIT_TICKS_RST = 13'd417;
    localparam logic [SYNC_W-1:0] SYNC_WORD_RST      = 16'hFFA5;

    // saturation limit for preamble and trailer
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic REG_HALF_BIT_TICKS = 1'b0;
    localparam logic REG_SYNC_WORD      = 1'b1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRE   = 4'b0010,
        ST_BITS  = 4'b0100,
        ST_TRAIL = 4'b1000
    } seq_state_t;

endpackage : mfpe_pkg

`default_nettype wire

>>> hdl/manchester_frame_pulse_encoder.sv
// ----------------------------------------------------------------------------
// manchester_frame_pulse_encoder
// turns start / data / end requests into manchester edge-to-edge intervals
// ----------------------------------------------------------------------------
// a taken request moves the sequencer from ST_IDLE to ST_PRE or ST_BITS, which loads
// the first interval into the output register; throughput: one interval per cycle from
//   one shared interval unit while m_tready allows; the next request is taken in ST_IDLE
// an unused command is taken and produces nothing
// output stalls (m_tready low) hold the sequencer, nothing is lost
// reset: sync, active low; line level 1, checksum 0, registers to defaults
`default_nettype none

module manchester_frame_pulse_encoder
    import mfpe_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    // configuration write port
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_addr,
    input  wire logic [SYNC_W-1:0]   cfg_wdata,

    // request stream
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  wire logic [CMD_W-1:0]    s_tuser,   // [1:0] cmd

    // interval stream
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [TICK_W-1:0]   m_tdata,   // [15:0] interval_ticks
    output      logic                m_tlast,   // last interval of this request
    output      logic                m_tuser    // [0] frame_end
);

    // configuration registers
    logic [HALF_W-1:0] half_ticks_reg;
    logic [SYNC_W-1:0] sync_word_reg;

    // sequencer state
    seq_state_t        state_reg, state_next;
    logic [SYNC_W-1:0] shift_reg, shift_next;     // bits to send, msb first
    logic [CNT_W-1:0]  cnt_reg, cnt_next;         // bits left minus one
    logic              half_pend_reg, half_pend_next;  // second half interval owed
    logic              trail_pend_reg, trail_pend_next; // trailer after the bits
    logic              level_reg, level_next;     // current line level
    logic [BYTE_W-1:0] csum_reg, csum_next;       // running checksum

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [TICK_W-1:0] m_ticks_reg, m_ticks_next;
    logic              m_last_reg, m_last_next;
    logic              m_fend_reg, m_fend_next;

    logic              in_req;
    logic              out_free;
    logic [TICK_W:0]   long_sum;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] half_ticks;
    logic [TICK_W-1:0] full_ticks;
    logic              cur_bit;
    logic              bit_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_req   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // interval unit: ten halves = 8h + 2h, saturated to 16 bits
    assign long_sum   = {1'b0, half_ticks_reg, 3'b000} + {3'b000, half_ticks_reg, 1'b0};
    assign long_ticks = long_sum[TICK_W] ? TICK_MAX : long_sum[TICK_W-1:0];
    assign half_ticks = {3'b000, half_ticks_reg};
    assign full_ticks = {2'b00, half_ticks_reg, 1'b0};

    assign cur_bit = shift_reg[SYNC_W-1];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_ticks_reg <= HALF_BIT_TICKS_RST;
            sync_word_reg  <= SYNC_WORD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_HALF_BIT_TICKS: half_ticks_reg <= cfg_wdata[HALF_W-1:0];
                REG_SYNC_WORD:      sync_word_reg  <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        half_pend_next  = half_pend_reg;
        trail_pend_next = trail_pend_reg;
        level_next      = level_reg;
        csum_next       = csum_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_ticks_next    = m_ticks_reg;
        m_last_next     = m_last_reg;
        m_fend_next     = m_fend_reg;
        bit_done        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    half_pend_next = 1'b0;
                    unique case (s_tuser)
                        CMD_START: begin
                            csum_next       = '0;
                            level_next      = 1'b1;
                            shift_next      = sync_word_reg;
                            cnt_next        = CNT_W'(SYNC_W - 1);
                            trail_pend_next = 1'b0;
                            state_next      = ST_PRE;
                        end
                        CMD_DATA: begin
                            csum_next       = csum_reg ^ s_tdata;
                            shift_next      = {s_tdata, {(SYNC_W-BYTE_W){1'b0}}};
                            cnt_next        = CNT_W'(BYTE_W - 1);
                            trail_pend_next = 1'b0;
                            state_next      = ST_BITS;
                        end
                        CMD_END: begin
                            shift_next      = {csum_reg, {(SYNC_W-BYTE_W){1'b0}}};
                            cnt_next        = CNT_W'(BYTE_W - 1);
                            trail_pend_next = 1'b1;
                            state_next      = ST_BITS;
                        end
                        CMD_NONE: ;   // unused command, nothing sent
                        default:  ;
                    endcase
                end
            end
            ST_PRE: begin
                // preamble interval
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ticks_next = long_ticks;
                    m_last_next  = 1'b0;
                    m_fend_next  = 1'b0;
                    state_next   = ST_BITS;
                end
            end
            ST_BITS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_fend_next  = 1'b0;
                    if (half_pend_reg) begin
                        // second half of a bit equal to the level
                        m_ticks_next   = half_ticks;
                        half_pend_next = 1'b0;
                        bit_done       = 1'b1;
                    end else if (cur_bit != level_reg) begin
                        // level change: one full bit interval
                        m_ticks_next = full_ticks;
                        level_next   = !level_reg;
                        bit_done     = 1'b1;
                    end else begin
                        m_ticks_next   = half_ticks;
                        half_pend_next = 1'b1;
                    end
                    m_last_next = bit_done && (cnt_reg == '0) && !trail_pend_reg;
                    if (bit_done) begin
                        if (cnt_reg == '0) begin
                            state_next = trail_pend_reg ? ST_TRAIL : ST_IDLE;
                        end else begin
                            cnt_next   = cnt_reg - 1'b1;
                            shift_next = {shift_reg[SYNC_W-2:0], 1'b0};
                        end
                    end
                end
            end
            ST_TRAIL: begin
                // trailer interval closes the frame
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_ticks_next    = long_ticks;
                    m_last_next     = 1'b1;
                    m_fend_next     = 1'b1;
                    trail_pend_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            half_pend_reg  <= 1'b0;
            trail_pend_reg <= 1'b0;
            level_reg      <= 1'b1;
            csum_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            half_pend_reg  <= half_pend_next;
            trail_pend_reg <= trail_pend_next;
            level_reg      <= level_next;
            csum_reg       <= csum_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        shift_reg   <= shift_next;
        m_ticks_reg <= m_ticks_next;
        m_last_reg  <= m_last_next;
        m_fend_reg  <= m_fend_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_ticks_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_fend_reg;

    // checks
    a_fend_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fend_reg) |-> m_last_reg)
        else $error("frame end interval not marked last");

    a_idle_no_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !half_pend_reg)
        else $error("half interval still owed while idle");

    a_start_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_req && (s_tuser == CMD_START)) |=> (level_reg && (csum_reg == '0)))
        else $error("start request did not reset level and checksum");

    a_trail_not_pre: assert property (@(posedge aclk) disable iff (!aresetn)
        trail_pend_reg |-> (state_reg != ST_PRE))
        else $error("trailer pending during preamble");

endmodule : manchester_frame_pulse_encoder

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the manchester frame pulse encoder
// ----------------------------------------------------------------------------
// requests (start / data / end / unused) fed from a queue by a clocked driver
// local encoder predicts every interval of each accepted request
// monitor checks the intervals in order
// several half-bit and sync settings, the extremes among them
// random idling on both sides, one long receiver hold-off stalls the input
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import mfpe_pkg::*;

    localparam int unsigned LONG_HALVES  = 10;    // preamble and trailer, in half bits
    localparam int unsigned DRAIN_CYCLES = 40;    // settle time before a register write
    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int unsigned QUIET_LIMIT  = 5000;  // watchdog, cycles with no transfer
    localparam int unsigned RAND_ITEMS   = 500;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data;
    } request_t;

    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic              last_run;
        logic              frame_end;
    } interval_t;

    // dut connections, all inputs known from time zero
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_addr  = REG_HALF_BIT_TICKS;
    logic [SYNC_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata   = '0;   // [7:0] data_byte
    logic [CMD_W-1:0]    s_tuser   = CMD_NONE;   // [1:0] cmd
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TICK_W-1:0]   m_tdata;   // [15:0] interval_ticks
    logic                m_tlast;
    logic                m_tuser;   // [0] frame_end

    // request queue for the driver, intervals still owed by the dut
    request_t  req_q[$];
    interval_t intervals_due[$];

    // local copy of the encoder state and registers
    logic [HALF_W-1:0] half_cfg = HALF_BIT_TICKS_RST;
    logic [SYNC_W-1:0] sync_cfg = SYNC_WORD_RST;
    logic              line_lvl = 1'b1;
    logic [BYTE_W-1:0] csum     = '0;

    // run control shared between processes
    bit          s_taken   = 1'b0;   // request accepted at the last rising edge
    bit          calm      = 1'b0;   // no idling on either side
    bit          hold_kick = 1'b0;   // ask the receiver for a long hold-off
    int unsigned hold_left = 0;
    int unsigned quiet_cnt = 0;
    int unsigned err_cnt   = 0;
    int unsigned n_req     = 0;
    int unsigned n_frames  = 0;
    int unsigned n_checked = 0;
    int unsigned n_cfg     = 0;
    int unsigned n_queued  = 0;   // random requests that do something

    manchester_frame_pulse_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // interval predictor
    // ------------------------------------------------------------------

    // one interval, long ones saturate at the 16-bit ceiling
    task automatic push_interval(input int unsigned ticks, input logic frame_end);
        interval_t iv;
        iv.ticks     = (ticks > 32'(TICK_MAX)) ? TICK_MAX : ticks[TICK_W-1:0];
        iv.last_run  = 1'b0;
        iv.frame_end = frame_end;
        intervals_due.push_back(iv);
    endtask

    // msb first; a bit equal to the line gives two halves, a change one full bit
    task automatic encode_bits(input logic [SYNC_W-1:0] value, input int nbits);
        int unsigned half;
        half = 32'(half_cfg);
        for (int i = nbits - 1; i >= 0; i--) begin
            if (value[i] != line_lvl) begin
                push_interval(2 * half, 1'b0);
                line_lvl = ~line_lvl;
            end else begin
                push_interval(half, 1'b0);
                push_interval(half, 1'b0);
            end
        end
    endtask

    task automatic encode_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
        int unsigned base;
        int unsigned long_ticks;
        interval_t   tail;
        base       = intervals_due.size();
        long_ticks = LONG_HALVES * 32'(half_cfg);
        case (cmd)
            CMD_START: begin
                csum     = '0;
                line_lvl = 1'b1;
                push_interval(long_ticks, 1'b0);
                encode_bits(sync_cfg, SYNC_W);
            end
            CMD_DATA: begin
                csum = csum ^ data;
                encode_bits({8'h00, data}, BYTE_W);
            end
            CMD_END: begin
                // the request's own byte is dropped, the checksum goes out
                encode_bits({8'h00, csum}, BYTE_W);
                push_interval(long_ticks, 1'b1);
            end
            default: ;   // unused command, nothing happens
        endcase
        if (intervals_due.size() > base) begin
            tail          = intervals_due.pop_back();
            tail.last_run = 1'b1;
            intervals_due.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: changes at the falling edge, holds until taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_req
        request_t nxt;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (req_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
                nxt = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // interval receiver: random back-pressure plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    // ------------------------------------------------------------------
    // monitor: register copies, prediction, interval checks, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        interval_t want;
        bit        moved;
        moved   = 1'b0;
        s_taken = 1'b0;
        if (aresetn) begin
            if (cfg_wr_en) begin
                moved = 1'b1;
                if (cfg_addr == REG_HALF_BIT_TICKS)
                    half_cfg = cfg_wdata[HALF_W-1:0];
                else
                    sync_cfg = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                moved   = 1'b1;
                s_taken = 1'b1;
                n_req++;
                if (s_tuser == CMD_START)
                    n_frames++;
                encode_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (intervals_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected interval: expected none, %s",
                             $time, "actual:");
                    $display("    ticks=%0d last=%0b end=%0b",
                             m_tdata, m_tlast, m_tuser);
                end else begin
                    want = intervals_due.pop_front();
                    n_checked++;
                    if (m_tdata !== want.ticks || m_tlast !== want.last_run
                        || m_tuser !== want.frame_end) begin
                        err_cnt++;
                        $display("%0t: interval mismatch: expected ticks=%0d last=%0b end=%0b",
                                 $time, want.ticks, want.last_run, want.frame_end);
                        $display("    actual ticks=%0d last=%0b end=%0b",
                                 m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
        quiet_cnt = moved ? 0 : quiet_cnt + 1;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d intervals outstanding",
                     $time, QUIET_LIMIT, intervals_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
        request_t r;
        r.cmd  = cmd;
        r.data = data;
        req_q.push_back(r);
        if (cmd != CMD_NONE)
            n_queued++;
    endtask

    // well-formed frame with random payload; the end byte is junk on purpose
    task automatic add_frame(input int unsigned n_bytes);
        add_req(CMD_START, 8'($urandom));
        repeat (n_bytes) add_req(CMD_DATA, 8'($urandom));
        add_req(CMD_END, 8'($urandom));
    endtask

    // stray requests: data or end outside a frame, restarts, unused codes
    task automatic add_noise();
        add_req(CMD_W'($urandom_range(3)), 8'($urandom));
    endtask

    task automatic write_reg(input logic addr, input logic [SYNC_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        n_cfg++;
    endtask

    // everything sent and answered, then a margin for a request with no output
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (req_q.size() != 0 || s_tvalid || intervals_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [SYNC_W-1:0] half_val;
        int unsigned       phase;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values
        add_req(CMD_DATA, 8'h5A);    // data before any start
        add_req(CMD_END,  8'h00);    // end before any start
        add_req(CMD_START, 8'hFF);
        add_req(CMD_DATA, 8'h00);
        add_req(CMD_DATA, 8'hFF);
        add_req(CMD_DATA, 8'hAA);
        add_req(CMD_DATA, 8'h55);
        add_req(CMD_DATA, 8'h80);
        add_req(CMD_DATA, 8'h01);
        add_req(CMD_NONE, 8'hFF);    // unused code inside a frame
        add_req(CMD_END,  8'hFF);    // byte must be ignored
        add_req(CMD_START, 8'h00);
        add_req(CMD_END,  8'h00);    // empty frame, checksum zero
        add_req(CMD_NONE, 8'h00);
        wait_drained();

        // register extremes: smallest, zero, largest unsaturated, saturating
        write_reg(REG_HALF_BIT_TICKS, 16'd1);
        write_reg(REG_SYNC_WORD, 16'h0000);
        add_frame(1);
        wait_drained();
        write_reg(REG_HALF_BIT_TICKS, 16'd0);
        write_reg(REG_SYNC_WORD, 16'hFFFF);
        add_frame(1);
        wait_drained();
        write_reg(REG_HALF_BIT_TICKS, 16'd6553);
        write_reg(REG_SYNC_WORD, 16'h5555);
        add_frame(1);
        wait_drained();
        write_reg(REG_HALF_BIT_TICKS, 16'd6554);
        write_reg(REG_SYNC_WORD, 16'hAAAA);
        add_frame(0);
        wait_drained();
        // upper write bits must be dropped by the half-bit register
        write_reg(REG_HALF_BIT_TICKS, 16'hFFFF);
        write_reg(REG_SYNC_WORD, 16'($urandom));
        add_frame(1);
        wait_drained();

        // random phases, each with its own register setting
        n_queued = 0;
        phase    = 0;
        while (n_queued < RAND_ITEMS) begin
            case ($urandom_range(9))
                0:       half_val = 16'd1;
                1:       half_val = 16'd8191;
                2:       half_val = 16'($urandom_range(6554, 8191)) | 16'(($urandom & 7) << HALF_W);
                default: half_val = 16'($urandom_range(1, 6553));
            endcase
            write_reg(REG_HALF_BIT_TICKS, half_val);
            write_reg(REG_SYNC_WORD, 16'($urandom));
            calm = (phase == 1);
            repeat (6) begin
                if ($urandom_range(99) < 80)
                    add_frame($urandom_range(99) < 85 ? $urandom_range(1, 8)
                                                     : $urandom_range(0, 16));
                else
                    repeat ($urandom_range(1, 3)) add_noise();
            end
            // receiver stalls while the queue keeps offering requests
            if (phase == 2) begin
                @(posedge aclk);
                hold_kick = 1'b1;
            end
            wait_drained();
            calm = 1'b0;
            phase++;
        end

        $display("run covered %0d requests in %0d frames, %0d register writes",
                 n_req, n_frames, n_cfg);
        $display("%0d intervals checked, %0d mismatches", n_checked, err_cnt);
        if (err_cnt == 0 && intervals_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb

`default_nettype wire
